// File: rtl/core/lsr_pkg.sv
// Shared types and constants of the L-system string rewriter.
package lsr_pkg;

  localparam int LETTERS = 26;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_Z = 8'h5A;

  typedef enum logic [2:0] {
    ACT_RULE_BYTE  = 3'd0,
    ACT_RULE_LEN   = 3'd1,
    ACT_START_BYTE = 3'd2,
    ACT_START_LEN  = 3'd3,
    ACT_GENERATE   = 3'd4,
    ACT_READ       = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/core/lsystem_string_rewriter.sv
// Top level of the L-system string rewriter: string stores, rule memory and rewrite sequencer.
//
// Rule byte, rule length, start byte, start length, read and unused actions complete at
// a rate of one item per cycle while the output is not stalled, each giving its result on
// the following cycle. A generate item keeps the input stalled while it runs its rounds.
// Each round ends in a fetch that finds the source used up; a copied byte (or one whose
// rule is empty) passes through fetch and decode, and an expanded letter through fetch,
// decode and one emit step per rule byte, as the string store and the rule memory each
// have a single registered read port. Bytes beyond MAX_STRING are dropped and the sticky
// overflow flag is set; setting the start length clears it. The string stores and the
// rule memory hold undefined data after reset and need no clearing pass.
module lsystem_string_rewriter #(
  parameter int MAX_STRING = 1024,
  parameter int RULE_MAX   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [4:0]  letter,
  input  logic [9:0]  position,
  input  logic [7:0]  char_value,
  input  logic [10:0] length,
  input  logic        registered,
  input  logic [7:0]  iterations,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_char,
  output logic [10:0] string_length,
  output logic        overflow
);

  localparam int SW         = $clog2(MAX_STRING);
  localparam int LW         = $clog2(MAX_STRING + 1);
  localparam int RW         = $clog2(RULE_MAX);
  localparam int RLW        = $clog2(RULE_MAX + 1);
  localparam int RULE_DEPTH = lsr_pkg::LETTERS * (2 ** RW);

  // Memories.
  logic [7:0] store_a [MAX_STRING];
  logic [7:0] store_b [MAX_STRING];
  logic [7:0] rule_mem [RULE_DEPTH];

  // Architectural state.
  lsr_pkg::state_t  state, state_next;
  logic [RLW-1:0]   rule_len [lsr_pkg::LETTERS];
  logic             rule_valid [lsr_pkg::LETTERS];
  logic [LW-1:0]    cur_len, cur_len_next;
  logic             bank, bank_next;
  logic             ovf, ovf_next;
  logic             out_valid_next;

  // Sequencer registers.
  logic [LW-1:0]    src_pos, src_pos_next;
  logic [LW-1:0]    dst_cnt, dst_cnt_next;
  logic [RW-1:0]    rule_pos, rule_pos_next;
  logic [7:0]       rounds, rounds_next;
  logic [4:0]       cur_idx, cur_idx_next;
  logic [RLW-1:0]   cur_rlen, cur_rlen_next;

  // Read result selection.
  logic             rd_hit, rd_hit_next;
  logic             rd_bank, rd_bank_next;

  // Memory ports.
  logic             st_we;
  logic             st_wbank;
  logic [SW-1:0]    st_waddr;
  logic [7:0]       st_wdata;
  logic             st_re;
  logic [SW-1:0]    st_raddr;
  logic [7:0]       a_rdata, b_rdata;
  logic             rule_we;
  logic             rule_re;
  logic [4+RW:0]    rule_raddr;
  logic [7:0]       rule_rdata;
  logic             rule_cfg_we;

  logic             accept;
  logic             out_take;
  lsr_pkg::action_t act;
  logic [7:0]       src_char;
  logic [7:0]       char_off;
  logic [4:0]       char_idx;
  logic             char_is_letter;
  logic             char_expand;
  logic             dst_room;

  assign out_take = out_valid && !out_stall;
  assign in_stall = (state != lsr_pkg::ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign act      = lsr_pkg::action_t'(action);

  assign src_char       = rd_bank ? b_rdata : a_rdata;
  assign char_off       = src_char - lsr_pkg::CHAR_A;
  assign char_idx       = char_off[4:0];
  assign char_is_letter = (src_char >= lsr_pkg::CHAR_A) && (src_char <= lsr_pkg::CHAR_Z);
  assign char_expand    = char_is_letter && rule_valid[char_idx];
  assign dst_room       = 32'(dst_cnt) < MAX_STRING;

  assign rule_we = accept && (act == lsr_pkg::ACT_RULE_BYTE) && (letter < 5'(lsr_pkg::LETTERS))
                   && (32'(position) < RULE_MAX);
  assign rule_cfg_we = accept && (act == lsr_pkg::ACT_RULE_LEN)
                       && (letter < 5'(lsr_pkg::LETTERS));

  assign read_char     = rd_hit ? src_char : 8'd0;
  assign string_length = 11'(cur_len);
  assign overflow      = ovf;

  always_comb begin
    state_next     = state;
    cur_len_next   = cur_len;
    bank_next      = bank;
    ovf_next       = ovf;
    out_valid_next = out_take ? 1'b0 : out_valid;
    src_pos_next   = src_pos;
    dst_cnt_next   = dst_cnt;
    rule_pos_next  = rule_pos;
    rounds_next    = rounds;
    cur_idx_next   = cur_idx;
    cur_rlen_next  = cur_rlen;
    rd_hit_next    = rd_hit;
    rd_bank_next   = rd_bank;
    st_we          = 1'b0;
    st_wbank       = ~bank;
    st_waddr       = SW'(dst_cnt);
    st_wdata       = src_char;
    st_re          = 1'b0;
    st_raddr       = SW'(src_pos);
    rule_re        = 1'b0;
    rule_raddr     = {cur_idx, rule_pos};

    case (state)
      lsr_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_next = 1'b1;
          rd_hit_next    = 1'b0;
          rd_bank_next   = bank;
          case (act)
            lsr_pkg::ACT_START_BYTE: begin
              st_we    = 32'(position) < MAX_STRING;
              st_wbank = bank;
              st_waddr = SW'(position);
              st_wdata = char_value;
            end
            lsr_pkg::ACT_START_LEN: begin
              cur_len_next = (32'(length) > MAX_STRING) ? LW'(MAX_STRING) : LW'(length);
              ovf_next     = 1'b0;
            end
            lsr_pkg::ACT_GENERATE: begin
              if (iterations != 8'd0) begin
                out_valid_next = 1'b0;
                rounds_next    = iterations;
                src_pos_next   = '0;
                dst_cnt_next   = '0;
                state_next     = lsr_pkg::ST_FETCH;
              end
            end
            lsr_pkg::ACT_READ: begin
              st_re       = 1'b1;
              st_raddr    = SW'(position);
              rd_hit_next = 32'(position) < 32'(cur_len);
            end
            default: begin
            end
          endcase
        end
      end

      lsr_pkg::ST_FETCH: begin
        if (src_pos < cur_len) begin
          st_re      = 1'b1;
          state_next = lsr_pkg::ST_DECODE;
        end else begin
          // The round is finished: the written store becomes the current string.
          bank_next    = ~bank;
          rd_bank_next = ~bank;
          cur_len_next = dst_cnt;
          src_pos_next = '0;
          dst_cnt_next = '0;
          rounds_next  = rounds - 8'd1;
          if (rounds == 8'd1) begin
            out_valid_next = 1'b1;
            state_next     = lsr_pkg::ST_IDLE;
          end
        end
      end

      lsr_pkg::ST_DECODE: begin
        if (char_expand) begin
          cur_idx_next  = char_idx;
          cur_rlen_next = rule_len[char_idx];
          rule_pos_next = '0;
          src_pos_next  = src_pos + LW'(1);
          if (rule_len[char_idx] == '0) begin
            state_next = lsr_pkg::ST_FETCH;
          end else begin
            rule_re    = 1'b1;
            rule_raddr = {char_idx, RW'(0)};
            state_next = lsr_pkg::ST_EMIT;
          end
        end else begin
          if (dst_room) begin
            st_we        = 1'b1;
            dst_cnt_next = dst_cnt + LW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          src_pos_next = src_pos + LW'(1);
          state_next   = lsr_pkg::ST_FETCH;
        end
      end

      lsr_pkg::ST_EMIT: begin
        st_wdata = rule_rdata;
        if (dst_room) begin
          st_we        = 1'b1;
          dst_cnt_next = dst_cnt + LW'(1);
        end else begin
          ovf_next = 1'b1;
        end
        // Rule bytes stream out one per cycle; the next one is fetched while this one is written.
        if ((RLW'(rule_pos) + RLW'(1)) < cur_rlen) begin
          rule_re       = 1'b1;
          rule_pos_next = rule_pos + RW'(1);
          rule_raddr    = {cur_idx, rule_pos + RW'(1)};
        end else begin
          state_next = lsr_pkg::ST_FETCH;
        end
      end

      default: begin
        state_next = lsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lsr_pkg::ST_IDLE;
      out_valid <= 1'b0;
      cur_len   <= '0;
      bank      <= 1'b0;
      ovf       <= 1'b0;
      rd_hit    <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cur_len   <= cur_len_next;
      bank      <= bank_next;
      ovf       <= ovf_next;
      rd_hit    <= rd_hit_next;
    end
  end

  always_ff @(posedge clk) begin
    src_pos  <= src_pos_next;
    dst_cnt  <= dst_cnt_next;
    rule_pos <= rule_pos_next;
    rounds   <= rounds_next;
    cur_idx  <= cur_idx_next;
    cur_rlen <= cur_rlen_next;
    rd_bank  <= rd_bank_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lsr_pkg::LETTERS; i++) begin
        rule_len[i]   <= '0;
        rule_valid[i] <= 1'b0;
      end
    end else if (rule_cfg_we) begin
      rule_len[letter]   <= (32'(length) > RULE_MAX) ? RLW'(RULE_MAX) : RLW'(length);
      rule_valid[letter] <= registered;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we && !st_wbank) begin
      store_a[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      a_rdata <= store_a[st_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we && st_wbank) begin
      store_b[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      b_rdata <= store_b[st_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rule_we) begin
      rule_mem[{letter, RW'(position)}] <= char_value;
    end
    if (rule_re) begin
      rule_rdata <= rule_mem[rule_raddr];
    end
  end

endmodule

// File: tb/lsr_status_check.sv
`timescale 1ns / 1ps
// Watches both channels of the string rewriter, predicts each status result and compares it.
module lsr_status_check #(
  parameter int MAX_STRING = 1024,
  parameter int RULE_MAX   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  action,
  input  logic [4:0]  letter,
  input  logic [9:0]  position,
  input  logic [7:0]  char_value,
  input  logic [10:0] length,
  input  logic        registered,
  input  logic [7:0]  iterations,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  read_char,
  input  logic [10:0] string_length,
  input  logic        overflow,
  output int          fail_count,
  output int          outstanding
);
  import lsr_pkg::*;

  typedef struct packed {
    logic [7:0]  read_char;
    logic [10:0] string_length;
    logic        overflow;
  } status_t;

  logic [7:0]  rule_mem [LETTERS][RULE_MAX];
  int unsigned rule_len [LETTERS];
  bit          rule_on [LETTERS];
  logic [7:0]  store [2][MAX_STRING];
  int unsigned cur_len;
  bit          cur_bank;
  bit          ovf;
  status_t     expected_status [$];

  initial begin
    foreach (store[b, i]) store[b][i] = '0;
    foreach (rule_mem[l, i]) rule_mem[l][i] = '0;
  end

  // One rewriting round: read the current bank, write the other one, then swap.
  function automatic void rewrite_pass();
    int unsigned count;
    int unsigned n;
    int unsigned m;
    int idx;
    logic [7:0] c;
    count = 0;
    for (n = 0; n < cur_len && n < MAX_STRING; n++) begin
      c = store[cur_bank][n];
      idx = int'(c) - int'(CHAR_A);
      if (c >= CHAR_A && c <= CHAR_Z && rule_on[idx]) begin
        for (m = 0; m < rule_len[idx]; m++) begin
          if (count < MAX_STRING) begin
            store[cur_bank ^ 1'b1][count] = rule_mem[idx][m];
            count++;
          end else begin
            ovf = 1'b1;
          end
        end
      end else if (count < MAX_STRING) begin
        store[cur_bank ^ 1'b1][count] = c;
        count++;
      end else begin
        ovf = 1'b1;
      end
    end
    cur_bank = cur_bank ^ 1'b1;
    cur_len = count;
  endfunction

  function automatic status_t predict_status(logic [2:0] act, logic [4:0] ltr, logic [9:0] pos,
                                             logic [7:0] val, logic [10:0] len, logic reg_bit,
                                             logic [7:0] rounds);
    status_t s;
    s.read_char = '0;
    case (act)
      ACT_RULE_BYTE: begin
        if (ltr < LETTERS && pos < RULE_MAX) rule_mem[ltr][pos] = val;
      end
      ACT_RULE_LEN: begin
        if (ltr < LETTERS) begin
          rule_len[ltr] = (len > RULE_MAX) ? RULE_MAX : len;
          rule_on[ltr] = reg_bit;
        end
      end
      ACT_START_BYTE: begin
        if (pos < MAX_STRING) store[cur_bank][pos] = val;
      end
      ACT_START_LEN: begin
        cur_len = (len > MAX_STRING) ? MAX_STRING : len;
        ovf = 1'b0;
      end
      ACT_GENERATE: begin
        repeat (rounds) rewrite_pass();
      end
      ACT_READ: begin
        if (pos < cur_len) s.read_char = store[cur_bank][pos];
      end
      default: ;
    endcase
    s.string_length = cur_len[10:0];
    s.overflow = ovf;
    return s;
  endfunction

  always @(posedge clk) begin : monitor
    status_t oldest;
    int errs;
    errs = 0;
    if (rst) begin
      foreach (rule_len[l]) begin
        rule_len[l] = 0;
        rule_on[l] = 1'b0;
      end
      cur_len = 0;
      cur_bank = 1'b0;
      ovf = 1'b0;
      expected_status.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_status.push_back(predict_status(action, letter, position, char_value, length,
                                                 registered, iterations));
      end
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $error("result transfer with no expectation waiting");
          errs++;
        end else begin
          oldest = expected_status.pop_front();
          if (read_char !== oldest.read_char) begin
            $error("read_char mismatch: expected %0d, actual %0d", oldest.read_char, read_char);
            errs++;
          end
          if (string_length !== oldest.string_length) begin
            $error("string_length mismatch: expected %0d, actual %0d",
                   oldest.string_length, string_length);
            errs++;
          end
          if (overflow !== oldest.overflow) begin
            $error("overflow mismatch: expected %0d, actual %0d", oldest.overflow, overflow);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    outstanding <= expected_status.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top of the string rewriter testbench: clock, reset, stimulus, output stalls and verdict.
module tb;
  import lsr_pkg::*;

  localparam int MAX_STRING = 1024;
  localparam int RULE_MAX = 64;
  localparam int TARGET_ITEMS = 900;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam int LETTER_A = 0;
  localparam int LETTER_H = 7;
  localparam int LETTER_Z = 25;
  localparam int LETTER_BAD = 31;
  localparam logic [7:0] CHAR_H = CHAR_A + 8'd7;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  action = '0;
  logic [4:0]  letter = '0;
  logic [9:0]  position = '0;
  logic [7:0]  char_value = '0;
  logic [10:0] length = '0;
  logic        registered = 1'b0;
  logic [7:0]  iterations = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_char;
  logic [10:0] string_length;
  logic        overflow;
  logic        random_phase = 1'b0;
  int          fail_count;
  int          outstanding;

  // What the stimulus knows to be written, so that no undefined entry is ever read.
  bit start_written [2][MAX_STRING];
  bit rule_written [LETTERS][RULE_MAX];
  bit cur_bank;
  bit sender_calm;
  int items_sent;
  int rounds_total;
  int action_count [8];

  lsystem_string_rewriter #(.MAX_STRING(MAX_STRING), .RULE_MAX(RULE_MAX)) dut (.*);

  lsr_status_check #(.MAX_STRING(MAX_STRING), .RULE_MAX(RULE_MAX)) status_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Output side: one long hold-off early in the random phase, a calm stretch, random otherwise.
  initial begin : receiver
    int unsigned since;
    since = 0;
    forever begin
      @(posedge clk);
      if (random_phase) since++;
      if (since >= 20 && since < 420) out_stall <= 1'b1;
      else if (since >= 3000 && since < 6000) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 33);
    end
  end

  task automatic send_item(logic [2:0] act, logic [4:0] ltr, logic [9:0] pos, logic [7:0] val,
                           logic [10:0] len, logic reg_bit, logic [7:0] rounds);
    if (!sender_calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    letter <= ltr;
    position <= pos;
    char_value <= val;
    length <= len;
    registered <= reg_bit;
    iterations <= rounds;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    action_count[act]++;
    if (act == ACT_START_BYTE) start_written[cur_bank][pos] = 1'b1;
    if (act == ACT_RULE_BYTE && ltr < LETTERS && pos < RULE_MAX) rule_written[ltr][pos] = 1'b1;
    if (act == ACT_GENERATE) begin
      rounds_total += rounds;
      cur_bank ^= rounds[0];
    end
  endtask

  // Bytes that are never letters, so that strings built from them cannot grow.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = $urandom;
    return c & 8'hBF;
  endfunction

  // Rule contents never name the long rule of H, which keeps round lengths bounded.
  function automatic logic [7:0] rule_char(int ltr);
    logic [7:0] c;
    if (ltr == LETTER_H) return plain_char();
    case ($urandom_range(0, 9))
      0: c = 8'h00;
      1, 2, 3, 4, 5: c = CHAR_A + 8'($urandom_range(0, 6));
      6: c = CHAR_A + 8'($urandom_range(8, LETTER_Z));
      default: c = $urandom;
    endcase
    return (c == CHAR_H) ? (c ^ 8'h20) : c;
  endfunction

  function automatic logic [7:0] start_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return CHAR_A + 8'($urandom_range(0, LETTER_H));
    if (pick < 65) return CHAR_A + 8'($urandom_range(LETTER_H + 1, LETTER_Z));
    return $urandom;
  endfunction

  function automatic int start_prefix(bit bank);
    int n;
    n = 0;
    while (n < MAX_STRING && start_written[bank][n]) n++;
    return n;
  endfunction

  function automatic bit rule_prefix_ok(int ltr, int n);
    int i;
    for (i = 0; i < n && i < RULE_MAX; i++)
      if (!rule_written[ltr][i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic load_rule(int ltr, int nbytes, int len_field, bit reg_bit);
    int i;
    for (i = 0; i < nbytes; i++)
      send_item(ACT_RULE_BYTE, ltr, i, rule_char(ltr), $urandom, $urandom, $urandom);
    send_item(ACT_RULE_LEN, ltr, $urandom, $urandom, len_field, reg_bit, $urandom);
  endtask

  task automatic load_start(int n, bit plain);
    int i;
    for (i = 0; i < n; i++)
      send_item(ACT_START_BYTE, $urandom, i, plain ? plain_char() : start_char(),
                $urandom, $urandom, $urandom);
    send_item(ACT_START_LEN, $urandom, $urandom, $urandom, n, $urandom, $urandom);
  endtask

  task automatic noise_item();
    logic [2:0] act;
    int ltr;
    int n;
    int len;
    bit reg_bit;
    act = $urandom_range(0, 7);
    ltr = $urandom_range(0, LETTER_BAD);
    case (act)
      ACT_RULE_BYTE: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_STRING - 1) :
                                          $urandom_range(0, RULE_MAX - 1);
        send_item(act, ltr, n, rule_char(ltr), $urandom, $urandom, $urandom);
      end
      ACT_RULE_LEN: begin
        reg_bit = $urandom_range(0, 1);
        len = $urandom_range(0, 2047);
        if (reg_bit && ltr < LETTERS) begin
          if (ltr != LETTER_H) len = $urandom_range(0, 6);
          if (!rule_prefix_ok(ltr, len)) reg_bit = 1'b0;
        end
        send_item(act, ltr, $urandom, $urandom, len, reg_bit, $urandom);
      end
      ACT_START_BYTE: begin
        send_item(act, ltr, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      ACT_START_LEN: begin
        n = start_prefix(cur_bank);
        len = $urandom_range(0, n);
        if (n == MAX_STRING && $urandom_range(0, 1)) len = $urandom_range(MAX_STRING + 1, 2047);
        send_item(act, ltr, $urandom, $urandom, len, $urandom, $urandom);
      end
      ACT_GENERATE: begin
        send_item(act, ltr, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
      end
      default: begin
        send_item(act, ltr, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    endcase
  endtask

  initial begin : stimulus
    int pick;
    int n;
    int full_rules;
    logic [7:0] rounds;
    full_rules = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty string, bank swap with no bytes, ignored writes, saturation and overflow.
    send_item(ACT_GENERATE, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
    send_item(ACT_GENERATE, $urandom, $urandom, $urandom, $urandom, $urandom, 1);
    send_item(ACT_START_BYTE, $urandom, MAX_STRING - 1, 8'hFF, $urandom, $urandom, $urandom);
    send_item(ACT_UNUSED_LO, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    repeat (4) send_item(ACT_RULE_BYTE, LETTER_A, rule_prefix_ok(LETTER_A, 1) +
                         rule_prefix_ok(LETTER_A, 2) + rule_prefix_ok(LETTER_A, 3) +
                         rule_prefix_ok(LETTER_A, 4) - 1 + rule_written[LETTER_A][0],
                         CHAR_A, $urandom, $urandom, $urandom);
    send_item(ACT_RULE_BYTE, LETTER_Z, MAX_STRING - 1, $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_RULE_BYTE, LETTER_BAD, 0, $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_RULE_LEN, LETTER_A, $urandom, $urandom, 4, 1'b1, $urandom);
    send_item(ACT_RULE_LEN, LETTER_BAD, $urandom, $urandom, 2047, 1'b1, $urandom);
    send_item(ACT_RULE_LEN, LETTER_Z, $urandom, $urandom, 2047, 1'b0, $urandom);
    send_item(ACT_START_BYTE, $urandom, 0, CHAR_A, $urandom, $urandom, $urandom);
    send_item(ACT_START_BYTE, $urandom, 1, 8'h00, $urandom, $urandom, $urandom);
    send_item(ACT_START_BYTE, $urandom, 2, CHAR_Z, $urandom, $urandom, $urandom);
    send_item(ACT_START_LEN, $urandom, $urandom, $urandom, 3, $urandom, $urandom);
    // Each A becomes four, so the fifth round runs past the store and the sixth stays full.
    send_item(ACT_GENERATE, $urandom, $urandom, $urandom, $urandom, $urandom, 6);
    foreach (start_written[cur_bank][i]) start_written[cur_bank][i] = 1'b1;
    send_item(ACT_READ, $urandom, MAX_STRING - 1, $urandom, $urandom, $urandom, $urandom);
    send_item(ACT_START_LEN, $urandom, $urandom, $urandom, 2047, $urandom, $urandom);
    send_item(ACT_READ, $urandom, 0, $urandom, $urandom, $urandom, $urandom);
    // An empty registered rule deletes every A of the full store.
    send_item(ACT_RULE_LEN, LETTER_A, $urandom, $urandom, 0, 1'b1, $urandom);
    send_item(ACT_GENERATE, $urandom, $urandom, $urandom, $urandom, $urandom, 1);
    send_item(ACT_READ, $urandom, 5, $urandom, $urandom, $urandom, $urandom);

    random_phase <= 1'b1;
    while (items_sent < TARGET_ITEMS) begin
      sender_calm = (items_sent >= 400 && items_sent < 560);
      pick = $urandom_range(0, 99);
      if (full_rules == 0 || (pick < 3 && full_rules < 3)) begin
        // Longest rule for H, from a length field at or above the rule size.
        load_rule(LETTER_H, RULE_MAX, $urandom_range(RULE_MAX, 2047), 1'b1);
        send_item(ACT_RULE_BYTE, LETTER_H, $urandom_range(RULE_MAX, MAX_STRING - 1),
                  $urandom, $urandom, $urandom, $urandom);
        full_rules++;
      end else if (pick < 8) begin
        // Many rounds over a string without letters.
        load_start($urandom_range(1, 4), 1'b1);
        send_item(ACT_GENERATE, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(128, 255));
        send_item(ACT_READ, $urandom, $urandom_range(0, 7), $urandom, $urandom, $urandom,
                  $urandom);
      end else if (pick < 75) begin
        repeat ($urandom_range(0, 2)) begin
          n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          load_rule($urandom_range(0, LETTER_H - 1), n, n, $urandom_range(0, 7) != 0);
        end
        load_start($urandom_range(1, 12), 1'b0);
        case ($urandom_range(0, 9))
          0: rounds = 0;
          1, 2, 3, 4: rounds = 1;
          5, 6, 7: rounds = 2;
          default: rounds = 3;
        endcase
        send_item(ACT_GENERATE, $urandom, $urandom, $urandom, $urandom, $urandom, rounds);
        repeat ($urandom_range(1, 4)) begin
          n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 80) :
                                           $urandom_range(0, MAX_STRING - 1);
          send_item(ACT_READ, $urandom, n, $urandom, $urandom, $urandom, $urandom);
        end
      end else begin
        noise_item();
      end
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d items: %0d rule bytes, %0d rule lengths, %0d start bytes, %0d start lengths,",
             items_sent, action_count[ACT_RULE_BYTE], action_count[ACT_RULE_LEN],
             action_count[ACT_START_BYTE], action_count[ACT_START_LEN]);
    $display("%0d generates over %0d rounds, %0d reads and %0d unused actions.",
             action_count[ACT_GENERATE], rounds_total, action_count[ACT_READ],
             action_count[ACT_UNUSED_LO] + action_count[ACT_UNUSED_HI]);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
